// ===== design/dnle_pkg.sv =====
// Shared types and constants of the DNS name label encoder.
// Payload structs, controller/datapath command and status structs.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none

package dnle_pkg;

  localparam int BYTE_W = 8;
  localparam int EMIT_W = 9;

  localparam logic [BYTE_W-1:0] DOT_CHAR  = 8'h2E;
  localparam logic [BYTE_W-1:0] LEN_SAT   = 8'hFF;
  localparam logic [EMIT_W-1:0] EMIT_SAT  = 9'h1FF;

  typedef struct packed {
    logic [BYTE_W-1:0] name_char;
    logic              end_of_name;
  } in_item_t;

  typedef struct packed {
    logic [BYTE_W-1:0] out_byte;
    logic              is_terminator;
    logic [BYTE_W-1:0] encoded_length;
    logic              encode_error;
  } out_item_t;

  // Controller to datapath
  typedef struct packed {
    logic store;      // write character into label buffer
    logic overflow;   // drop character, flag error
    logic start;      // rewind read index for a flush
    logic emit_len;   // load length byte into output register
    logic emit_chr;   // load buffered character into output register
    logic emit_term;  // load terminator into output register
  } dp_cmd_t;

  // Datapath to controller
  typedef struct packed {
    logic in_dot;
    logic in_eon;
    logic label_empty;
    logic label_full;
    logic last_chr;
    logic slot_free;
  } dp_sts_t;

endpackage

`default_nettype wire

// ===== design/dnle_ram.sv =====
// Generic simple dual-port RAM: one write port, one read port, registered read.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none

module dnle_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 62,
  localparam int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  wire logic              clk,
  input  wire logic              we,
  input  wire logic [ADDR_W-1:0] waddr,
  input  wire logic [WIDTH-1:0]  wdata,
  input  wire logic [ADDR_W-1:0] raddr,
  output logic      [WIDTH-1:0]  rdata
);

  logic [WIDTH-1:0] mem_r [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem_r[waddr] <= wdata;
    end
    rdata_r <= mem_r[raddr];
  end

  assign rdata = rdata_r;

endmodule

`default_nettype wire

// ===== design/dnle_ctrl.sv =====
// Sequencing controller of the DNS name label encoder.
// Depends on dnle_pkg (command and status structs).
`timescale 1ns / 1ps
`default_nettype none

module dnle_ctrl (
  input  wire logic             clk,
  input  wire logic             rst_n,
  input  wire logic             in_valid,
  output logic                  in_ready,
  input  wire dnle_pkg::dp_sts_t sts,
  output dnle_pkg::dp_cmd_t     cmd
);

  localparam logic [1:0] S_IDLE = 2'd0;
  localparam logic [1:0] S_LEN  = 2'd1;
  localparam logic [1:0] S_CHR  = 2'd2;
  localparam logic [1:0] S_TERM = 2'd3;

  logic [1:0] state_r, state_nxt;
  logic       term_pend_r, term_pend_nxt;

  assign in_ready = (state_r == S_IDLE);

  always_comb begin
    state_nxt     = state_r;
    term_pend_nxt = term_pend_r;
    cmd           = '0;
    unique case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          if (sts.in_eon) begin
            term_pend_nxt = 1'b1;
            if (sts.label_empty) begin
              state_nxt = S_TERM;
            end else begin
              cmd.start = 1'b1;
              state_nxt = S_LEN;
            end
          end else if (sts.in_dot) begin
            term_pend_nxt = 1'b0;
            cmd.start     = 1'b1;
            state_nxt     = S_LEN;
          end else if (sts.label_full) begin
            cmd.overflow = 1'b1;
          end else begin
            cmd.store = 1'b1;
          end
        end
      end
      S_LEN: begin
        if (sts.slot_free) begin
          cmd.emit_len = 1'b1;
          if (!sts.label_empty) begin
            state_nxt = S_CHR;
          end else if (term_pend_r) begin
            state_nxt = S_TERM;
          end else begin
            state_nxt = S_IDLE;
          end
        end
      end
      S_CHR: begin
        if (sts.slot_free) begin
          cmd.emit_chr = 1'b1;
          if (sts.last_chr) begin
            state_nxt = term_pend_r ? S_TERM : S_IDLE;
          end
        end
      end
      S_TERM: begin
        if (sts.slot_free) begin
          cmd.emit_term = 1'b1;
          term_pend_nxt = 1'b0;
          state_nxt     = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      term_pend_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      term_pend_r <= term_pend_nxt;
    end
  end

endmodule

`default_nettype wire

// ===== design/dnle_dp.sv =====
// Datapath of the DNS name label encoder: label buffer, counters, output register.
// Depends on dnle_pkg and dnle_ram.
`timescale 1ns / 1ps
`default_nettype none

module dnle_dp #(
  parameter int MAX_LABEL = 62,
  parameter int MAX_NAME  = 255
) (
  input  wire logic                clk,
  input  wire logic                rst_n,
  input  wire dnle_pkg::in_item_t  in_data,
  output dnle_pkg::out_item_t      out_data,
  output logic                     out_valid,
  input  wire logic                out_ready,
  input  wire dnle_pkg::dp_cmd_t   cmd,
  output dnle_pkg::dp_sts_t        sts
);

  localparam int ADDR_W = (MAX_LABEL > 1) ? $clog2(MAX_LABEL) : 1;
  localparam int CNT_W  = $clog2(MAX_LABEL + 1);
  localparam int SUM_W  = dnle_pkg::EMIT_W + 1;

  logic [CNT_W-1:0]             count_r, count_nxt;
  logic [ADDR_W-1:0]            idx_r, idx_nxt;
  logic [dnle_pkg::EMIT_W-1:0]  bytes_r, bytes_nxt;
  logic                         err_r, err_nxt;
  dnle_pkg::out_item_t          out_r, out_nxt;
  logic                         out_valid_r, out_valid_nxt;

  logic [dnle_pkg::BYTE_W-1:0]  rd_data;
  logic [SUM_W-1:0]             bytes_sum;
  logic                         last_chr;

  assign last_chr  = ((CNT_W'(idx_r) + CNT_W'(1)) == count_r);
  assign bytes_sum = SUM_W'(bytes_r) + SUM_W'(count_r) + SUM_W'(1);

  assign sts.in_dot      = !in_data.end_of_name && (in_data.name_char == dnle_pkg::DOT_CHAR);
  assign sts.in_eon      = in_data.end_of_name;
  assign sts.label_empty = (count_r == '0);
  assign sts.label_full  = (count_r == CNT_W'(MAX_LABEL));
  assign sts.last_chr    = last_chr;
  assign sts.slot_free   = !out_valid_r || out_ready;

  // Read address runs one step ahead so buffered data is ready when emitted
  always_comb begin
    idx_nxt = idx_r;
    if (cmd.start) begin
      idx_nxt = '0;
    end else if (cmd.emit_chr) begin
      idx_nxt = last_chr ? '0 : idx_r + ADDR_W'(1);
    end
  end

  dnle_ram #(
    .WIDTH (dnle_pkg::BYTE_W),
    .DEPTH (MAX_LABEL)
  ) u_label_ram (
    .clk   (clk),
    .we    (cmd.store),
    .waddr (count_r[ADDR_W-1:0]),
    .wdata (in_data.name_char),
    .raddr (idx_nxt),
    .rdata (rd_data)
  );

  always_comb begin
    count_nxt     = count_r;
    bytes_nxt     = bytes_r;
    err_nxt       = err_r;
    out_nxt       = out_r;
    out_valid_nxt = out_valid_r;

    if (out_ready) begin
      out_valid_nxt = 1'b0;
    end

    if (cmd.store) begin
      count_nxt = count_r + CNT_W'(1);
    end
    if (cmd.overflow) begin
      err_nxt = 1'b1;
    end

    if (cmd.emit_len) begin
      out_nxt.out_byte       = dnle_pkg::BYTE_W'(count_r);
      out_nxt.is_terminator  = 1'b0;
      out_nxt.encoded_length = '0;
      out_nxt.encode_error   = 1'b0;
      out_valid_nxt          = 1'b1;
      bytes_nxt = (bytes_sum > SUM_W'(dnle_pkg::EMIT_SAT)) ? dnle_pkg::EMIT_SAT
                                                           : bytes_sum[dnle_pkg::EMIT_W-1:0];
    end

    if (cmd.emit_chr) begin
      out_nxt.out_byte       = rd_data;
      out_nxt.is_terminator  = 1'b0;
      out_nxt.encoded_length = '0;
      out_nxt.encode_error   = 1'b0;
      out_valid_nxt          = 1'b1;
      if (last_chr) begin
        count_nxt = '0;
      end
    end

    if (cmd.emit_term) begin
      out_nxt.out_byte       = '0;
      out_nxt.is_terminator  = 1'b1;
      out_nxt.encoded_length = (bytes_r >= dnle_pkg::EMIT_W'(dnle_pkg::LEN_SAT))
                               ? dnle_pkg::LEN_SAT
                               : bytes_r[dnle_pkg::BYTE_W-1:0] + dnle_pkg::BYTE_W'(1);
      out_nxt.encode_error   = err_r || (bytes_r >= dnle_pkg::EMIT_W'(MAX_NAME));
      out_valid_nxt          = 1'b1;
      count_nxt              = '0;
      bytes_nxt              = '0;
      err_nxt                = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r     <= '0;
      bytes_r     <= '0;
      err_r       <= 1'b0;
      out_valid_r <= 1'b0;
      idx_r       <= '0;
    end else begin
      count_r     <= count_nxt;
      bytes_r     <= bytes_nxt;
      err_r       <= err_nxt;
      out_valid_r <= out_valid_nxt;
      idx_r       <= idx_nxt;
    end
  end

  always_ff @(posedge clk) begin
    out_r <= out_nxt;
  end

  assign out_data  = out_r;
  assign out_valid = out_valid_r;

endmodule

`default_nettype wire

// ===== design/dns_name_label_encoder.sv =====
// DNS name label encoder, top level: controller plus datapath.
// Depends on dnle_pkg, dnle_ctrl, dnle_dp (and dnle_ram beneath it).
//
// Usage: feed a dotted host name one character per input transfer on
// in_valid/in_ready/in_data. A dot closes the current label (an empty one
// too); an item with end_of_name set closes a non-empty pending label and
// then produces the zero terminator. The wire form leaves on
// out_valid/out_ready/out_data, one byte per transfer: length byte, label
// characters, terminator. encoded_length and encode_error mean something on
// the terminator only and read zero elsewhere.
// Flow: an ordinary character is stored in the label buffer and yields
// nothing. A dot with n buffered characters occupies the block through the
// accept, the length byte and each character in turn; end of name adds the
// terminator, and with nothing pending is accepted, then gives the terminator.
// The first result is registered and is loaded in the length (or terminator)
// state that follows the dot or end-of-name transfer. The pace of a flush is
// set by the single output register and the label RAM's one read port.
// Characters are accepted while a finished result still waits in the output
// register; a stalled receiver only holds the flush sequence.
// Reset (rst_n low, synchronous) empties the label, clears the byte count and
// error flag and drops any pending result. No clearing pass is needed.
`timescale 1ns / 1ps
`default_nettype none

module dns_name_label_encoder #(
  parameter int MAX_LABEL = 62,
  parameter int MAX_NAME  = 255
) (
  input  wire logic                clk,
  input  wire logic                rst_n,
  input  wire logic                in_valid,
  output logic                     in_ready,
  input  wire dnle_pkg::in_item_t  in_data,
  output logic                     out_valid,
  input  wire logic                out_ready,
  output dnle_pkg::out_item_t      out_data
);

  dnle_pkg::dp_cmd_t cmd;
  dnle_pkg::dp_sts_t sts;

  // Sequence each input transfer into store, drop or flush steps
  dnle_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .sts      (sts),
    .cmd      (cmd)
  );

  // Hold the label, count bytes and drive the output register
  dnle_dp #(
    .MAX_LABEL (MAX_LABEL),
    .MAX_NAME  (MAX_NAME)
  ) u_dp (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_data   (in_data),
    .out_data  (out_data),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .cmd       (cmd),
    .sts       (sts)
  );

  // At most one datapath action per cycle
  a_one_cmd: assert property (@(posedge clk) disable iff (!rst_n)
    $onehot0({cmd.store, cmd.overflow, cmd.start, cmd.emit_len, cmd.emit_chr,
              cmd.emit_term}))
    else $error("controller issued more than one datapath command");

  // Never overwrite a result the receiver has not taken
  a_emit_free: assert property (@(posedge clk) disable iff (!rst_n)
    (cmd.emit_len || cmd.emit_chr || cmd.emit_term) |-> sts.slot_free)
    else $error("result loaded while output register still occupied");

  // A loaded result is offered in the next cycle
  a_emit_valid: assert property (@(posedge clk) disable iff (!rst_n)
    (cmd.emit_len || cmd.emit_chr || cmd.emit_term) |=> out_valid)
    else $error("loaded result not presented");

  // Never write past the end of the label buffer
  a_store_room: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.store |-> !sts.label_full)
    else $error("character stored into full label buffer");

endmodule

`default_nettype wire
